[rtl/core/window_median_time_past_macros.svh]
// assertion macros used by the checker file
`ifndef WINDOW_MEDIAN_TIME_PAST_MACROS_SVH
`define WINDOW_MEDIAN_TIME_PAST_MACROS_SVH

// same-cycle implication, masked during reset
`define WMTP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked during reset
`define WMTP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also checks reset behaviour
`define WMTP_ASSERT_RESET(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/wmtp_pkg.sv]
package wmtp_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned HELD_W = 4;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic push;  // shift the held timestamps one cell along
        logic load;  // copy held timestamps into the circulating ring
        logic step;  // compare and rotate the ring by one cell
    } t_cell_ctl;

    // timestamp travelling round the ring
    typedef struct packed {
        logic              vld;
        logic [TIME_W-1:0] stamp;
    } t_pass;

endpackage

[rtl/core/wmtp_cell.sv]
module wmtp_cell #(
    parameter int unsigned WINDOW = 11,
    parameter int unsigned IDX    = 0,
    parameter int unsigned CW     = $clog2(WINDOW + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  wmtp_pkg::t_cell_ctl          i_ctl,
    input  logic [CW-1:0]                i_fill,
    input  logic [wmtp_pkg::TIME_W-1:0]  i_own,
    input  wmtp_pkg::t_pass              i_pass,
    output logic [wmtp_pkg::TIME_W-1:0]  o_own,
    output wmtp_pkg::t_pass              o_pass,
    output logic                         o_match
);

    logic [wmtp_pkg::TIME_W-1:0] r_own;
    wmtp_pkg::t_pass             r_pass;
    logic [CW-1:0]               r_below;
    logic [CW-1:0]               r_at;
    logic [CW-1:0]               w_rank;
    logic                        w_held;

    // held timestamp, shifted along the chain on each push
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_own <= i_own;
        end
    end

    // circulating copy and rank counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass.vld <= 1'b0;
            r_below    <= '0;
            r_at       <= '0;
        end else if (i_ctl.load) begin
            r_pass.vld   <= w_held;
            r_pass.stamp <= r_own;
            r_below      <= '0;
            r_at         <= '0;
        end else if (i_ctl.step) begin
            r_pass <= i_pass;
            if (r_pass.vld && w_held) begin
                if (r_pass.stamp < r_own) begin
                    r_below <= r_below + 1'b1;
                end
                if (r_pass.stamp <= r_own) begin
                    r_at <= r_at + 1'b1;
                end
            end
        end
    end

    // this cell holds a written entry once the fill count passes its index
    assign w_held  = (i_fill > CW'(IDX));
    assign w_rank  = i_fill >> 1;
    assign o_match = w_held && (r_below <= w_rank) && (w_rank < r_at);
    assign o_own   = r_own;
    assign o_pass  = r_pass;

endmodule

[rtl/core/window_median_time_past.sv]
// running median of the last WINDOW block timestamps
//
// input channel: i_in_valid / o_in_stall with i_block_time. an item is taken
// at a clock edge where i_in_valid is high and o_in_stall is low.
// output channel: o_out_valid / i_out_stall with o_median_time and
// o_held_count, one result item for every input item.
//
// the timestamps sit in a chain of WINDOW cells; a push shifts them one cell
// along. a copy of every held timestamp then circulates round the ring while
// each cell counts the entries below and at or below its own value; the cell
// whose rank range covers held_count/2 gives the median. the sequencer steps
// through load, run (the ring rotates by one cell per cycle) and done, which
// writes the result to the output register. one item is in flight at a time:
// the input stalls from acceptance until the sequencer is back in idle.
// reset (synchronous, active low) empties the window and drops any pending
// result. while the receiver stalls, the result holds in the output register
// and the next item may be taken; its result waits until the register frees.
module window_median_time_past #(
    parameter int unsigned WINDOW = 11
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [wmtp_pkg::TIME_W-1:0]  i_block_time,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [wmtp_pkg::TIME_W-1:0]  o_median_time,
    output logic [wmtp_pkg::HELD_W-1:0]  o_held_count
);

    localparam int unsigned CW = $clog2(WINDOW + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_RUN,
        S_DONE
    } t_state;

    t_state                      r_state;
    t_state                      n_state;
    logic [CW-1:0]               r_fill;
    logic [CW-1:0]               n_fill;
    logic [CW-1:0]               r_step;
    logic [CW-1:0]               n_step;
    logic                        r_out_valid;
    logic                        n_out_valid;
    logic [wmtp_pkg::TIME_W-1:0] r_median;
    logic [wmtp_pkg::TIME_W-1:0] n_median;
    logic [wmtp_pkg::HELD_W-1:0] r_held;
    logic [wmtp_pkg::HELD_W-1:0] n_held;

    wmtp_pkg::t_cell_ctl         w_ctl;
    logic                        w_in_acc;
    logic                        w_out_free;
    logic [wmtp_pkg::TIME_W-1:0] w_own  [WINDOW];
    wmtp_pkg::t_pass             w_pass [WINDOW];
    logic [WINDOW-1:0]           w_match;
    logic [wmtp_pkg::TIME_W-1:0] w_pick;

    assign w_in_acc   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    // row of cells: held values shift forward, circulating copies form a ring
    for (genvar k = 0; k < WINDOW; k++) begin : g_cell
        localparam int unsigned PREV = (k + WINDOW - 1) % WINDOW;
        logic [wmtp_pkg::TIME_W-1:0] w_own_in;

        if (k == 0) begin : g_head
            assign w_own_in = i_block_time;
        end else begin : g_body
            assign w_own_in = w_own[k-1];
        end

        wmtp_cell #(
            .WINDOW (WINDOW),
            .IDX    (k),
            .CW     (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_fill  (r_fill),
            .i_own   (w_own_in),
            .i_pass  (w_pass[PREV]),
            .o_own   (w_own[k]),
            .o_pass  (w_pass[k]),
            .o_match (w_match[k])
        );
    end

    // matching cells all hold the same value, so an or-merge picks it
    always_comb begin
        w_pick = '0;
        for (int k = 0; k < WINDOW; k++) begin
            if (w_match[k]) begin
                w_pick = w_pick | w_own[k];
            end
        end
    end

    // cell control
    always_comb begin
        w_ctl.push = w_in_acc;
        w_ctl.load = (r_state == S_LOAD);
        w_ctl.step = (r_state == S_RUN);
    end

    // sequencer next state
    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_step      = r_step;
        n_out_valid = r_out_valid;
        n_median    = r_median;
        n_held      = r_held;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (r_fill != CW'(WINDOW)) begin
                        n_fill = r_fill + 1'b1;
                    end
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_step  = '0;
                n_state = S_RUN;
            end
            S_RUN: begin
                n_step = r_step + 1'b1;
                if (r_step == CW'(WINDOW - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_median    = w_pick;
                    n_held      = wmtp_pkg::HELD_W'(r_fill);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // sequencer state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
        r_median <= n_median;
        r_held   <= n_held;
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_median_time = r_median;
    assign o_held_count  = r_held;

endmodule

[rtl/core/wmtp_checker.sv]
`include "window_median_time_past_macros.svh"

module wmtp_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_stall,
    input logic [wmtp_pkg::TIME_W-1:0]  i_block_time,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic [wmtp_pkg::TIME_W-1:0]  o_median_time,
    input logic [wmtp_pkg::HELD_W-1:0]  o_held_count
);

    // an accepted item keeps the block busy on the following cycle
    `WMTP_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall, "not busy after accept")

    // a new result appears only as the block returns to taking items
    `WMTP_ASSERT_NOW(a_result_frees_input, $rose(o_out_valid), !o_in_stall, "result while busy")

    // a stalled result holds its payload
    `WMTP_ASSERT_NEXT(a_stall_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_median_time) && $stable(o_held_count), "stalled result changed")

    // reset empties both channels
    `WMTP_ASSERT_RESET(a_reset_clear, !i_rst_n, !o_out_valid && !o_in_stall, "reset not clean")

endmodule

bind window_median_time_past wmtp_checker u_wmtp_checker (.*);
